// ===== design/sxl_pkg.sv =====
// shared types and constants for the s-expression token lexer
package sxl_pkg;

    // token kinds
    localparam logic [3:0] KIND_LPAREN = 4'd0;
    localparam logic [3:0] KIND_RPAREN = 4'd1;
    localparam logic [3:0] KIND_LMAP   = 4'd2;
    localparam logic [3:0] KIND_RMAP   = 4'd3;
    localparam logic [3:0] KIND_LVEC   = 4'd4;
    localparam logic [3:0] KIND_RVEC   = 4'd5;
    localparam logic [3:0] KIND_QUOTE  = 4'd6;
    localparam logic [3:0] KIND_QQUOTE = 4'd7;
    localparam logic [3:0] KIND_UNQ    = 4'd8;
    localparam logic [3:0] KIND_SPLICE = 4'd9;
    localparam logic [3:0] KIND_STRING = 4'd10;
    localparam logic [3:0] KIND_NUMBER = 4'd11;
    localparam logic [3:0] KIND_SYMBOL = 4'd12;
    localparam logic [3:0] KIND_EOF    = 4'd13;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_ESCAPE = 2'd1;
    localparam logic [1:0] ERR_UNTERM_STR = 2'd2;

    // characters with a meaning of their own
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0d;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_SEMI      = 8'h3b;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_LBRACE    = 8'h7b;
    localparam logic [7:0] CH_RBRACE    = 8'h7d;
    localparam logic [7:0] CH_LBRACKET  = 8'h5b;
    localparam logic [7:0] CH_RBRACKET  = 8'h5d;
    localparam logic [7:0] CH_APOS      = 8'h27;
    localparam logic [7:0] CH_BACKTICK  = 8'h60;
    localparam logic [7:0] CH_COMMA     = 8'h2c;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_MINUS     = 8'h2d;
    localparam logic [7:0] CH_DOT       = 8'h2e;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOWER_N   = 8'h6e;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // one result item
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] text;
        logic       is_text;
        logic [1:0] err;
    } result_t;

    // queue entry: one or two results caused by one input byte
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== design/sxl_front.sv =====
// front part: accepts source bytes, runs the lexer state and forms result entries
module sxl_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          end_of_input,
    input  logic          queue_full,
    output logic          push,
    output sxl_pkg::entry_t push_entry
);
    import sxl_pkg::*;

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_COMMENT = 6'b000010,
        MODE_COMMA   = 6'b000100,
        MODE_STRING  = 6'b001000,
        MODE_ESCAPE  = 6'b010000,
        MODE_TEXT    = 6'b100000
    } mode_t;

    // outcome of lexing one byte between tokens
    typedef struct packed {
        mode_t   mode;
        logic    has;
        result_t res;
        logic    start_text;
    } idle_out_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] first_byte_reg, first_byte_next;
    logic       second_dig_reg, second_dig_next;
    logic [1:0] text_count_reg, text_count_next;
    result_t    res0, res1;
    logic [1:0] res_count;
    idle_out_t  ib;
    logic       accept;
    logic       is_number;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic result_t token(input logic [3:0] kind, input logic [1:0] err);
        result_t r;
        r.kind    = kind;
        r.text    = 8'd0;
        r.is_text = 1'b0;
        r.err     = err;
        return r;
    endfunction

    function automatic result_t text_res(input logic [3:0] kind, input logic [7:0] c);
        result_t r;
        r.kind    = kind;
        r.text    = c;
        r.is_text = 1'b1;
        r.err     = ERR_NONE;
        return r;
    endfunction

    function automatic idle_out_t idle_byte(input logic [7:0] c);
        idle_out_t o;
        o.mode       = MODE_IDLE;
        o.has        = 1'b1;
        o.res        = token(KIND_LPAREN, ERR_NONE);
        o.start_text = 1'b0;
        if (is_ws(c))
        begin
            o.has = 1'b0;
        end
        else
        begin
            case (c)
                CH_SEMI:     begin o.mode = MODE_COMMENT; o.has = 1'b0; end
                CH_LPAREN:   o.res = token(KIND_LPAREN, ERR_NONE);
                CH_RPAREN:   o.res = token(KIND_RPAREN, ERR_NONE);
                CH_LBRACE:   o.res = token(KIND_LMAP, ERR_NONE);
                CH_RBRACE:   o.res = token(KIND_RMAP, ERR_NONE);
                CH_LBRACKET: o.res = token(KIND_LVEC, ERR_NONE);
                CH_RBRACKET: o.res = token(KIND_RVEC, ERR_NONE);
                CH_APOS:     o.res = token(KIND_QUOTE, ERR_NONE);
                CH_BACKTICK: o.res = token(KIND_QQUOTE, ERR_NONE);
                CH_COMMA:    begin o.mode = MODE_COMMA; o.has = 1'b0; end
                CH_DQUOTE:   begin o.mode = MODE_STRING; o.has = 1'b0; end
                default:
                begin
                    o.mode       = MODE_TEXT;
                    o.start_text = 1'b1;
                    o.res        = text_res(KIND_SYMBOL, c);
                end
            endcase
        end
        return o;
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign ib       = idle_byte(in_byte);

    // kind of the symbol or number that is ending now
    assign is_number = is_dig(first_byte_reg) ||
                       (((first_byte_reg == CH_MINUS) || (first_byte_reg == CH_DOT)) &&
                        second_dig_reg);

    // lexer step for the byte on the input
    always_comb
    begin
        mode_next       = mode_reg;
        first_byte_next = first_byte_reg;
        second_dig_next = second_dig_reg;
        text_count_next = text_count_reg;
        res0            = token(KIND_EOF, ERR_NONE);
        res1            = token(KIND_EOF, ERR_NONE);
        res_count       = 2'd0;
        case (mode_reg)
            MODE_COMMENT:
            begin
                if (end_of_input)
                begin
                    mode_next = MODE_IDLE;
                    res_count = 2'd1;
                end
                else if (in_byte == CH_NEWLINE)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_COMMA:
            begin
                mode_next = MODE_IDLE;
                res0      = token(KIND_UNQ, ERR_NONE);
                if (end_of_input)
                begin
                    res_count = 2'd2;
                end
                else if (in_byte == CH_AT)
                begin
                    res0      = token(KIND_SPLICE, ERR_NONE);
                    res_count = 2'd1;
                end
                else
                begin
                    mode_next = ib.mode;
                    res1      = ib.res;
                    res_count = ib.has ? 2'd2 : 2'd1;
                    if (ib.start_text)
                    begin
                        first_byte_next = in_byte;
                        second_dig_next = 1'b0;
                        text_count_next = 2'd1;
                    end
                end
            end
            MODE_STRING, MODE_ESCAPE:
            begin
                if (end_of_input)
                begin
                    mode_next = MODE_IDLE;
                    res0      = token(KIND_STRING, ERR_UNTERM_STR);
                    res_count = 2'd2;
                end
                else if (mode_reg == MODE_STRING)
                begin
                    if (in_byte == CH_DQUOTE)
                    begin
                        mode_next = MODE_IDLE;
                        res0      = token(KIND_STRING, ERR_NONE);
                        res_count = 2'd1;
                    end
                    else if (in_byte == CH_BACKSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        res0      = text_res(KIND_STRING, in_byte);
                        res_count = 2'd1;
                    end
                end
                else
                begin
                    // escape decode
                    mode_next = MODE_STRING;
                    res_count = 2'd1;
                    case (in_byte)
                        CH_BACKSLASH: res0 = text_res(KIND_STRING, CH_BACKSLASH);
                        CH_LOWER_N:   res0 = text_res(KIND_STRING, CH_NEWLINE);
                        CH_LOWER_R:   res0 = text_res(KIND_STRING, CH_CR);
                        CH_LOWER_T:   res0 = text_res(KIND_STRING, CH_TAB);
                        CH_DQUOTE:    res0 = text_res(KIND_STRING, CH_DQUOTE);
                        default:
                        begin
                            mode_next = MODE_IDLE;
                            res0      = token(KIND_STRING, ERR_BAD_ESCAPE);
                        end
                    endcase
                end
            end
            MODE_TEXT:
            begin
                res0 = token(is_number ? KIND_NUMBER : KIND_SYMBOL, ERR_NONE);
                if (end_of_input)
                begin
                    mode_next = MODE_IDLE;
                    res_count = 2'd2;
                end
                else if (is_ws(in_byte))
                begin
                    mode_next = MODE_IDLE;
                    res_count = 2'd1;
                end
                else if ((in_byte == CH_RPAREN) || (in_byte == CH_RBRACE) ||
                         (in_byte == CH_RBRACKET))
                begin
                    mode_next = MODE_IDLE;
                    res1      = ib.res;
                    res_count = 2'd2;
                end
                else
                begin
                    if (text_count_reg == 2'd1)
                    begin
                        second_dig_next = is_dig(in_byte);
                    end
                    if (text_count_reg < 2'd2)
                    begin
                        text_count_next = text_count_reg + 2'd1;
                    end
                    res0      = text_res(KIND_SYMBOL, in_byte);
                    res_count = 2'd1;
                end
            end
            default:
            begin
                // between tokens, unused codes included
                mode_next = MODE_IDLE;
                if (end_of_input)
                begin
                    res_count = 2'd1;
                end
                else
                begin
                    mode_next = ib.mode;
                    res0      = ib.res;
                    res_count = ib.has ? 2'd1 : 2'd0;
                    if (ib.start_text)
                    begin
                        first_byte_next = in_byte;
                        second_dig_next = 1'b0;
                        text_count_next = 2'd1;
                    end
                end
            end
        endcase
    end

    // entry toward the queue
    assign push              = accept && (res_count != 2'd0);
    assign push_entry.two    = (res_count == 2'd2);
    assign push_entry.first  = res0;
    assign push_entry.second = res1;

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            first_byte_reg <= 8'd0;
            second_dig_reg <= 1'b0;
            text_count_reg <= 2'd0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            first_byte_reg <= first_byte_next;
            second_dig_reg <= second_dig_next;
            text_count_reg <= text_count_next;
        end
    end

endmodule

// ===== design/sxl_fifo.sv =====
// short register queue between the front and back parts
module sxl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = store_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== design/sxl_back.sv =====
// back part: drains queue entries one result per cycle into the output register, while the receiver is ready
module sxl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            queue_empty,
    input  sxl_pkg::entry_t head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output sxl_pkg::result_t out_res,
    output logic            out_last
);
    import sxl_pkg::*;

    logic    phase_reg, phase_next;
    logic    valid_reg, valid_next;
    result_t res_reg, res_next;
    logic    last_reg, last_next;
    logic    load;

    // output register may take a new result
    assign load = !valid_reg || out_ready;

    // pick the result to show and step through the entry
    always_comb
    begin
        phase_next = phase_reg;
        valid_next = valid_reg && !out_ready;
        res_next   = res_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load && !queue_empty)
        begin
            valid_next = 1'b1;
            if (!phase_reg)
            begin
                res_next = head.first;
                if (head.two)
                begin
                    last_next  = 1'b0;
                    phase_next = 1'b1;
                end
                else
                begin
                    last_next = 1'b1;
                    pop       = 1'b1;
                end
            end
            else
            begin
                res_next   = head.second;
                last_next  = 1'b1;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

endmodule

// ===== design/sexpr_token_lexer_unit.sv =====
// top level of the s-expression token lexer
//
// The source text enters on the s_axis channel, one byte per transfer in
// s_axis_tdata; a transfer with s_axis_tlast high marks end of input and its
// byte is ignored. Tokens leave on the m_axis channel, one result per
// transfer: kind, text byte, text flag and error code in m_axis_tdata, and
// m_axis_tlast high on the final result caused by one input byte.
// Bytes that cause no result (whitespace, comments, string openers, the
// comma before its lookahead byte) produce no output transfer.
// A result reaches m_axis through the queue and then the output register.
// Source bytes are taken at one byte per cycle while the queue is not full;
// the output register gives one result per cycle while m_axis_tready is
// high, so a byte that causes two results is sent as two transfers and the
// queue between front and back soaks up the difference.
// When the receiver stalls, results pile up in the queue; s_axis_tready
// falls only while the queue is full.
// Reset clears the lexer to between tokens, empties the queue and drops
// m_axis_tvalid.
module sexpr_token_lexer_unit #(
    parameter int QueueDepth = sxl_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte [7:0]
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // token_kind [3:0], text_byte [11:4],
                                        // is_text [12], error_code [14:13], zero [15]
    output logic        m_axis_tlast    // last_of_run
);
    import sxl_pkg::*;

    entry_t  push_entry;
    entry_t  head;
    logic    push, pop, queue_full, queue_empty;
    logic [ENTRY_W-1:0] head_bits;
    result_t out_res;

    // classify bytes
    sxl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_byte      (s_axis_tdata),
        .end_of_input (s_axis_tlast),
        .queue_full   (queue_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    // decoupling queue
    sxl_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QueueDepth)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_entry),
        .full  (queue_full),
        .pop   (pop),
        .dout  (head_bits),
        .empty (queue_empty)
    );

    assign head = entry_t'(head_bits);

    // emit results
    sxl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_res     (out_res),
        .out_last    (m_axis_tlast)
    );

    // pack the result fields, first field lowest
    assign m_axis_tdata = {1'b0, out_res.err, out_res.is_text, out_res.text, out_res.kind};

endmodule

// ===== test/sexpr_token_lexer_unit_test.sv =====
// self-checking testbench for the s-expression token lexer
`timescale 1ns / 1ps

module sexpr_token_lexer_unit_test;
    import sxl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 100;

    // lexer modes of the predictor
    typedef enum logic [2:0] {
        LX_IDLE,
        LX_COMMENT,
        LX_COMMA,
        LX_STRING,
        LX_ESCAPE,
        LX_TEXT
    } lex_mode_t;

    // one predicted output transfer
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] text;
        logic       is_text;
        logic [1:0] err;
        logic       last;
    } token_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // in_byte [7:0]
    logic        s_axis_tlast = 1'b0;    // end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // token_kind [3:0], text_byte [11:4],
                                         // is_text [12], error_code [14:13], zero [15]
    logic        m_axis_tlast;           // last_of_run

    // predictor state
    lex_mode_t   lex_mode = LX_IDLE;
    logic [7:0]  first_byte = 8'h00;
    logic        second_digit = 1'b0;
    logic [1:0]  text_len = 2'd0;
    token_t      step_tokens[$];
    token_t      expected_tokens[$];

    // run control and statistics
    bit idle_on = 1'b1;
    int hold_cycles = 0;
    int quiet_cycles = 0;
    int error_count = 0;
    int bytes_sent = 0;
    int end_marks = 0;
    int results_checked = 0;
    int errors_flagged = 0;

    sexpr_token_lexer_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // token predictor
    // ---------------------------------------------------------------

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic emit(input logic [3:0] kind, input logic [7:0] text,
                        input logic is_text, input logic [1:0] err);
        token_t t;
        t.kind    = kind;
        t.text    = text;
        t.is_text = is_text;
        t.err     = err;
        t.last    = 1'b0;
        step_tokens.push_back(t);
    endtask

    // a byte seen between tokens
    task automatic lex_fresh(input logic [7:0] c);
        lex_mode = LX_IDLE;
        if (is_space(c))
            return;
        case (c)
            CH_SEMI:     lex_mode = LX_COMMENT;
            CH_LPAREN:   emit(KIND_LPAREN, 8'h00, 1'b0, ERR_NONE);
            CH_RPAREN:   emit(KIND_RPAREN, 8'h00, 1'b0, ERR_NONE);
            CH_LBRACE:   emit(KIND_LMAP, 8'h00, 1'b0, ERR_NONE);
            CH_RBRACE:   emit(KIND_RMAP, 8'h00, 1'b0, ERR_NONE);
            CH_LBRACKET: emit(KIND_LVEC, 8'h00, 1'b0, ERR_NONE);
            CH_RBRACKET: emit(KIND_RVEC, 8'h00, 1'b0, ERR_NONE);
            CH_APOS:     emit(KIND_QUOTE, 8'h00, 1'b0, ERR_NONE);
            CH_BACKTICK: emit(KIND_QQUOTE, 8'h00, 1'b0, ERR_NONE);
            CH_COMMA:    lex_mode = LX_COMMA;
            CH_DQUOTE:   lex_mode = LX_STRING;
            default:
            begin
                lex_mode     = LX_TEXT;
                first_byte   = c;
                second_digit = 1'b0;
                text_len     = 2'd1;
                emit(KIND_SYMBOL, c, 1'b1, ERR_NONE);
            end
        endcase
    endtask

    // token end of a symbol or number, kind decided by its first two bytes
    task automatic close_text();
        bit num;
        num = is_digit(first_byte) ||
              ((first_byte == CH_MINUS || first_byte == CH_DOT) && second_digit);
        lex_mode = LX_IDLE;
        emit(num ? KIND_NUMBER : KIND_SYMBOL, 8'h00, 1'b0, ERR_NONE);
    endtask

    // expected results of one accepted source byte
    task automatic predict_tokens(input logic [7:0] c, input logic eoi);
        logic [7:0] decoded;
        bit         valid_escape;
        step_tokens.delete();
        case (lex_mode)
            LX_COMMENT:
            begin
                if (eoi)
                begin
                    lex_mode = LX_IDLE;
                    emit(KIND_EOF, 8'h00, 1'b0, ERR_NONE);
                end
                else if (c == CH_NEWLINE)
                    lex_mode = LX_IDLE;
            end
            LX_COMMA:
            begin
                lex_mode = LX_IDLE;
                if (eoi)
                begin
                    emit(KIND_UNQ, 8'h00, 1'b0, ERR_NONE);
                    emit(KIND_EOF, 8'h00, 1'b0, ERR_NONE);
                end
                else if (c == CH_AT)
                    emit(KIND_SPLICE, 8'h00, 1'b0, ERR_NONE);
                else
                begin
                    emit(KIND_UNQ, 8'h00, 1'b0, ERR_NONE);
                    lex_fresh(c);
                end
            end
            LX_STRING, LX_ESCAPE:
            begin
                if (eoi)
                begin
                    lex_mode = LX_IDLE;
                    emit(KIND_STRING, 8'h00, 1'b0, ERR_UNTERM_STR);
                    emit(KIND_EOF, 8'h00, 1'b0, ERR_NONE);
                end
                else if (lex_mode == LX_STRING)
                begin
                    if (c == CH_DQUOTE)
                    begin
                        lex_mode = LX_IDLE;
                        emit(KIND_STRING, 8'h00, 1'b0, ERR_NONE);
                    end
                    else if (c == CH_BACKSLASH)
                        lex_mode = LX_ESCAPE;
                    else
                        emit(KIND_STRING, c, 1'b1, ERR_NONE);
                end
                else
                begin
                    // escape decode
                    valid_escape = 1'b1;
                    decoded      = 8'h00;
                    case (c)
                        CH_BACKSLASH: decoded = CH_BACKSLASH;
                        CH_LOWER_N:   decoded = CH_NEWLINE;
                        CH_LOWER_R:   decoded = CH_CR;
                        CH_LOWER_T:   decoded = CH_TAB;
                        CH_DQUOTE:    decoded = CH_DQUOTE;
                        default:      valid_escape = 1'b0;
                    endcase
                    if (valid_escape)
                    begin
                        lex_mode = LX_STRING;
                        emit(KIND_STRING, decoded, 1'b1, ERR_NONE);
                    end
                    else
                    begin
                        lex_mode = LX_IDLE;
                        emit(KIND_STRING, 8'h00, 1'b0, ERR_BAD_ESCAPE);
                    end
                end
            end
            LX_TEXT:
            begin
                if (eoi)
                begin
                    close_text();
                    emit(KIND_EOF, 8'h00, 1'b0, ERR_NONE);
                end
                else if (is_space(c))
                    close_text();
                else if (c == CH_RPAREN || c == CH_RBRACE || c == CH_RBRACKET)
                begin
                    close_text();
                    lex_fresh(c);
                end
                else
                begin
                    if (text_len == 2'd1)
                        second_digit = is_digit(c);
                    if (text_len < 2'd2)
                        text_len = text_len + 2'd1;
                    emit(KIND_SYMBOL, c, 1'b1, ERR_NONE);
                end
            end
            default:
            begin
                lex_mode = LX_IDLE;
                if (eoi)
                    emit(KIND_EOF, 8'h00, 1'b0, ERR_NONE);
                else
                    lex_fresh(c);
            end
        endcase
        if (step_tokens.size() != 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endtask

    // ---------------------------------------------------------------
    // source side
    // ---------------------------------------------------------------

    // one source transfer, with an occasional gap in front of it
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eoi;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_tokens(b, eoi);
        bytes_sent++;
        if (eoi)
            end_marks++;
    endtask

    task automatic send_end();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // stop sending and wait until every predicted result is out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            if (error_count < MAX_REPORTS)
                $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_checked++;
            if (m_axis_tdata[14:13] != ERR_NONE)
                errors_flagged++;
            if (expected_tokens.size() == 0)
            begin
                if (error_count < MAX_REPORTS)
                    $error("result with none expected: tdata %h tlast %b",
                           m_axis_tdata, m_axis_tlast);
                error_count++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("token_kind", 8'(want.kind), 8'(m_axis_tdata[3:0]));
                check_field("text_byte", want.text, m_axis_tdata[11:4]);
                check_field("is_text", 8'(want.is_text), 8'(m_axis_tdata[12]));
                check_field("error_code", 8'(want.err), 8'(m_axis_tdata[14:13]));
                check_field("last_of_run", 8'(want.last), 8'(m_axis_tlast));
            end
        end
    end

    // receiver stalls in random bursts while idle_on is set
    always @(posedge clk)
    begin
        logic ready_next;
        ready_next = 1'b1;
        if (hold_cycles != 0)
        begin
            hold_cycles = hold_cycles - 1;
            ready_next  = 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            hold_cycles = $urandom_range(0, 8);
            ready_next  = 1'b0;
        end
        m_axis_tready <= ready_next;
    end

    // cycles without any transfer on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL sexpr_token_lexer_unit");
        $finish;
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // every bracket and quote character
    task automatic test_brackets();
        send_byte(CH_LPAREN, 1'b0);
        send_byte(CH_RPAREN, 1'b0);
        send_byte(CH_LBRACE, 1'b0);
        send_byte(CH_RBRACE, 1'b0);
        send_byte(CH_LBRACKET, 1'b0);
        send_byte(CH_RBRACKET, 1'b0);
        send_byte(CH_APOS, 1'b0);
        send_byte(CH_BACKTICK, 1'b0);
    endtask

    // splice, unquote followed by a token, unquote at end of input
    task automatic test_comma();
        send_byte(CH_COMMA, 1'b0);
        send_byte(CH_AT, 1'b0);
        send_byte(CH_COMMA, 1'b0);
        send_byte(CH_RBRACKET, 1'b0);
        send_byte(CH_COMMA, 1'b0);
        send_byte(8'hff, 1'b1);
    endtask

    // good escape, bad escape, end of input inside a string
    task automatic test_strings();
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_LOWER_T, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte("z", 1'b0);
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // negative number, symbol with extreme bytes closed by a bracket,
    // symbol closed by end of input
    task automatic test_text();
        send_byte(CH_MINUS, 1'b0);
        send_byte("7", 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_RPAREN, 1'b0);
        send_byte("a", 1'b0);
        send_end();
    endtask

    // comment closed by newline, comment closed by end of input
    task automatic test_comments();
        send_byte(CH_SEMI, 1'b0);
        send_byte(CH_LPAREN, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_SEMI, 1'b0);
        send_end();
    endtask

    // mostly well-formed source with random content, plus some noise
    task automatic test_random_forms(input int count);
        int         stop_at;
        int         pick;
        int         len;
        logic [7:0] b;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                // whitespace run
                len = $urandom_range(1, 3);
                repeat (len)
                    send_byte(($urandom_range(0, 1) == 0) ? CH_SPACE
                              : 8'($urandom_range(CH_TAB, CH_CR)), 1'b0);
            end
            else if (pick < 30)
            begin
                // bracket or quote
                case ($urandom_range(0, 7))
                    0: b = CH_LPAREN;
                    1: b = CH_RPAREN;
                    2: b = CH_LBRACE;
                    3: b = CH_RBRACE;
                    4: b = CH_LBRACKET;
                    5: b = CH_RBRACKET;
                    6: b = CH_APOS;
                    default: b = CH_BACKTICK;
                endcase
                send_byte(b, 1'b0);
            end
            else if (pick < 40)
            begin
                // comma and its lookahead
                send_byte(CH_COMMA, 1'b0);
                case ($urandom_range(0, 5))
                    0, 1, 2: send_byte(CH_AT, 1'b0);
                    3:       send_end();
                    default: send_byte(8'($urandom_range(0, 255)), 1'b0);
                endcase
            end
            else if (pick < 55)
            begin
                // string with plain bytes and escapes
                send_byte(CH_DQUOTE, 1'b0);
                len = $urandom_range(0, 6);
                repeat (len)
                begin
                    case ($urandom_range(0, 11))
                        0:
                        begin
                            send_byte(CH_BACKSLASH, 1'b0);
                            case ($urandom_range(0, 4))
                                0: b = CH_BACKSLASH;
                                1: b = CH_LOWER_N;
                                2: b = CH_LOWER_R;
                                3: b = CH_LOWER_T;
                                default: b = CH_DQUOTE;
                            endcase
                            send_byte(b, 1'b0);
                        end
                        1:
                        begin
                            if ($urandom_range(0, 3) == 0)
                            begin
                                send_byte(CH_BACKSLASH, 1'b0);
                                send_byte(8'($urandom_range(0, 255)), 1'b0);
                            end
                        end
                        default:
                        begin
                            b = 8'($urandom_range(0, 255));
                            if (b == CH_DQUOTE || b == CH_BACKSLASH)
                                b = "s";
                            send_byte(b, 1'b0);
                        end
                    endcase
                end
                case ($urandom_range(0, 15))
                    0:       send_end();
                    1:       ; // left open, the next bytes land in the string
                    default: send_byte(CH_DQUOTE, 1'b0);
                endcase
            end
            else if (pick < 80)
            begin
                // symbol or number
                case ($urandom_range(0, 5))
                    0, 1: b = 8'($urandom_range(CH_ZERO, CH_NINE));
                    2:    b = CH_MINUS;
                    3:    b = CH_DOT;
                    4:    b = 8'($urandom_range("a", "z"));
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b, 1'b0);
                len = $urandom_range(0, 5);
                repeat (len)
                    send_byte(($urandom_range(0, 1) == 0)
                              ? 8'($urandom_range(CH_ZERO, CH_NINE))
                              : 8'($urandom_range(0, 255)), 1'b0);
                case ($urandom_range(0, 9))
                    0, 1, 2: send_byte(CH_SPACE, 1'b0);
                    3:       send_byte(CH_NEWLINE, 1'b0);
                    4:       send_byte(CH_RPAREN, 1'b0);
                    5:       send_byte(CH_RBRACE, 1'b0);
                    6:       send_byte(CH_RBRACKET, 1'b0);
                    7:       send_end();
                    default: ; // next form follows directly
                endcase
            end
            else if (pick < 88)
            begin
                // comment to end of line
                send_byte(CH_SEMI, 1'b0);
                len = $urandom_range(0, 8);
                repeat (len)
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(CH_NEWLINE, 1'b0);
            end
            else if (pick < 91)
                send_end();
            else
                send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_brackets();
        test_comma();
        test_strings();
        test_text();
        test_comments();
        test_random_forms(600);
        drain_results();
        test_random_forms(600);
        idle_on = 1'b0;
        test_random_forms(200);
        drain_results();

        $display("sent %0d source bytes with %0d end-of-input marks", bytes_sent, end_marks);
        $display("checked %0d result transfers, %0d of them lexer errors",
                 results_checked, errors_flagged);
        if (error_count == 0)
            $display("PASS sexpr_token_lexer_unit");
        else
            $display("FAIL sexpr_token_lexer_unit");
        $finish;
    end

endmodule
